// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/gld_pkg.sv =====
// Package: status codes, widths and helpers for the LZW decoder.
`timescale 1ns / 1ps
package gld_pkg;
    localparam int TableEntries = 4096;
    localparam int IdxW = $clog2(TableEntries);
    localparam int MaxWidth = 12;

    typedef enum logic [3:0] {
        ST_PIXEL     = 4'd0,
        ST_TAKEN     = 4'd1,
        ST_REFUSED   = 4'd2,
        ST_NEED      = 4'd3,
        ST_DONE      = 4'd4,
        ST_BAD_FIRST = 4'd5,
        ST_BAD_CODE  = 4'd6,
        ST_BAD_CHAIN = 4'd7,
        ST_TRUNC     = 4'd8
    } t_status;

    localparam logic [0:0] OP_BYTE  = 1'b0;
    localparam logic [0:0] OP_PIXEL = 1'b1;
    localparam logic [0:0] REG_MIN_SIZE = 1'b0;
    localparam logic [0:0] REG_PIXELS   = 1'b1;

    // Clamp the configured code size to 2..8.
    function automatic logic [3:0] eff_size(input logic [3:0] s);
        logic [3:0] r;
        r = s;
        if (s < 4'd2) r = 4'd2;
        if (s > 4'd8) r = 4'd8;
        return r;
    endfunction
endpackage

// ===== rtl/gld_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gld_ram #(
    parameter int Width = 8,
    parameter int Depth = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/gif_lzw_decoder.sv =====
// GIF LZW decoder: one item in, one status/pixel result out.
//
// Input channel (i_valid/o_stall) carries an operation: a compressed byte
// (operation 0, data_byte, final_byte) or a pixel request (operation 1).
// Each accepted item yields exactly one result on the output channel
// (o_valid/i_stall): status, pixel_index, last_pixel.
// Path from the input transfer to the result: a byte, or any item once decoding
// has stopped, goes straight to the result register. A pixel popped from the
// string stack goes through the stack RAM read, then the result register. A
// status found at decode time, or the first literal after a clear, passes the
// decode state first. A pixel that needs a new code walks the prefix chain at
// one cycle per link through the prefix/suffix RAMs, then pops the stack. Each
// clear code read on the way takes another pass through the decode state.
// One item is in flight at a time; the result register holds the answer
// while the receiver stalls, and the next item is taken in the cycle after
// it leaves.
// Reset (synchronous, i_rst_n low) sets min_code_size 8, pixel_count 1 and
// restarts the decoder; a configuration write also restarts it. Tables are
// not cleared: entries are always written before they are read.
// Errors and done are sticky until the next restart.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gif_lzw_decoder
    import gld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic [7:0]  o_pixel_index,
    output logic        o_last_pixel,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [26:0] i_cfg_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_WALK, S_POP, S_OUT
    } t_state;

    t_state       r_state;
    logic [3:0]   r_min_size;
    logic [26:0]  r_pixel_count;
    logic [12:0]  r_next_free;
    logic [3:0]   r_width;
    logic [23:0]  r_buf;
    logic [4:0]   r_held;
    logic [11:0]  r_prev_code;
    logic         r_prev_valid;
    logic [7:0]   r_first_sym;
    logic [12:0]  r_depth;
    logic [26:0]  r_emitted;
    logic         r_ended;
    logic [3:0]   r_finish;
    logic [11:0]  r_code;
    logic [11:0]  r_incoming;
    logic [12:0]  r_top;
    logic         r_valid;
    logic [3:0]   r_status;
    logic [7:0]   r_pix;
    logic         r_last;

    logic [3:0]   size;
    logic [12:0]  cc, ec;
    assign size = eff_size(r_min_size);
    assign cc = 13'd1 << size;
    assign ec = cc + 13'd1;

    // memories
    logic               pt_we, st_we, sk_we;
    logic [IdxW-1:0]    pt_waddr, tb_raddr, sk_waddr, sk_raddr;
    logic [11:0]        pt_wdata, pt_rdata;
    logic [7:0]         st_wdata, st_rdata, sk_wdata, sk_rdata;

    gld_ram #(.Width(12), .Depth(TableEntries)) u_prefix (
        .i_clk, .i_we(pt_we), .i_waddr(pt_waddr), .i_wdata(pt_wdata),
        .i_raddr(tb_raddr), .o_rdata(pt_rdata));
    gld_ram #(.Width(8), .Depth(TableEntries)) u_suffix (
        .i_clk, .i_we(st_we), .i_waddr(pt_waddr), .i_wdata(st_wdata),
        .i_raddr(tb_raddr), .o_rdata(st_rdata));
    gld_ram #(.Width(8), .Depth(TableEntries)) u_stack (
        .i_clk, .i_we(sk_we), .i_waddr(sk_waddr), .i_wdata(sk_wdata),
        .i_raddr(sk_raddr), .o_rdata(sk_rdata));

    logic        in_xfer, out_xfer;
    logic [11:0] mask, cur_code;
    logic [12:0] nf_next;
    logic [26:0] em_inc;
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = o_valid && !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign mask     = 12'((13'd1 << r_width) - 13'd1);
    assign cur_code = r_buf[11:0] & mask;
    assign nf_next  = r_next_free + 13'd1;
    assign em_inc   = r_emitted + 27'd1;

    // write/read control (combinational, from state)
    logic walk_push;
    assign walk_push = (r_state == S_WALK) && !(13'(r_code) < cc) &&
                       !(13'(r_code) == cc || 13'(r_code) == ec) &&
                       !(r_top >= 13'(TableEntries));

    always_comb begin
        pt_we    = 1'b0;
        st_we    = 1'b0;
        pt_waddr = r_next_free[IdxW-1:0];
        pt_wdata = r_prev_code;
        st_wdata = r_code[7:0];
        sk_we    = 1'b0;
        sk_waddr = r_top[IdxW-1:0];
        sk_wdata = r_first_sym;
        tb_raddr = r_code;
        sk_raddr = r_depth[IdxW-1:0] - 12'd1;
        if (r_state == S_DECODE) begin
            // special case: code equals next free code pushes first symbol
            sk_we    = r_prev_valid && (13'(cur_code) == r_next_free) &&
                       (r_held >= 5'(r_width)) && (13'(cur_code) != cc) &&
                       (13'(cur_code) != ec);
            sk_waddr = '0;
            tb_raddr = (13'(cur_code) == r_next_free) ? r_prev_code : cur_code;
        end else if (r_state == S_WALK) begin
            if (walk_push) begin
                sk_we    = 1'b1;
                sk_wdata = st_rdata;
                tb_raddr = pt_rdata;
            end else if (13'(r_code) < cc && !(r_top >= 13'(TableEntries))) begin
                sk_we    = 1'b1;
                sk_wdata = r_code[7:0];
                pt_we    = r_next_free < 13'(TableEntries);
                st_we    = pt_we;
                sk_raddr = r_top[IdxW-1:0];
            end
        end
    end

    // marks that S_OUT must first take the popped pixel from the stack RAM read
    logic r_from_ram;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            if (!i_rst_n) begin
                r_min_size    <= 4'd8;
                r_pixel_count <= 27'd1;
            end else if (i_cfg_index == REG_MIN_SIZE) begin
                r_min_size <= i_cfg_data[3:0];
            end else begin
                r_pixel_count <= i_cfg_data;
            end
            r_state      <= S_IDLE;
            r_next_free  <= (13'd1 << eff_size(!i_rst_n ? 4'd8 :
                            (i_cfg_index == REG_MIN_SIZE ? i_cfg_data[3:0] : r_min_size)))
                            + 13'd2;
            r_width      <= eff_size(!i_rst_n ? 4'd8 :
                            (i_cfg_index == REG_MIN_SIZE ? i_cfg_data[3:0] : r_min_size))
                            + 4'd1;
            r_buf        <= '0;
            r_held       <= '0;
            r_prev_code  <= '0;
            r_prev_valid <= 1'b0;
            r_first_sym  <= '0;
            r_depth      <= '0;
            r_emitted    <= '0;
            r_ended      <= 1'b0;
            r_finish     <= ST_PIXEL;
            r_valid      <= 1'b0;
            r_from_ram   <= 1'b0;
        end else begin
            if (out_xfer) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_pix  <= '0;
                        r_last <= 1'b0;
                        if (r_finish != ST_PIXEL) begin
                            r_status <= r_finish;
                            r_state  <= S_OUT;
                        end else if (i_operation == OP_BYTE) begin
                            if (r_held > 5'd16 || r_ended) begin
                                r_status <= ST_REFUSED;
                            end else begin
                                r_buf   <= r_buf | (24'(i_data_byte) << r_held);
                                r_held  <= r_held + 5'd8;
                                r_ended <= i_final_byte;
                                r_status <= ST_TAKEN;
                            end
                            r_state <= S_OUT;
                        end else if (r_emitted >= r_pixel_count) begin
                            r_finish <= ST_DONE;
                            r_status <= ST_DONE;
                            r_state  <= S_OUT;
                        end else if (r_depth != 13'd0) begin
                            r_state <= S_POP;
                        end else begin
                            r_state <= S_DECODE;
                        end
                    end
                end
                S_DECODE: begin
                    if (r_held < 5'(r_width)) begin
                        r_state <= S_OUT;
                        if (r_ended) begin
                            r_finish <= ST_TRUNC;
                            r_status <= ST_TRUNC;
                        end else begin
                            r_status <= ST_NEED;
                        end
                    end else begin
                        r_buf  <= r_buf >> r_width;
                        r_held <= r_held - 5'(r_width);
                        if (13'(cur_code) == cc) begin
                            r_next_free  <= cc + 13'd2;
                            r_width      <= size + 4'd1;
                            r_prev_valid <= 1'b0;
                            r_state      <= S_DECODE;
                        end else if (13'(cur_code) == ec) begin
                            r_finish <= ST_TRUNC;
                            r_status <= ST_TRUNC;
                            r_state  <= S_OUT;
                        end else if (!r_prev_valid) begin
                            r_state <= S_OUT;
                            if (13'(cur_code) >= cc) begin
                                r_finish <= ST_BAD_FIRST;
                                r_status <= ST_BAD_FIRST;
                            end else begin
                                r_first_sym  <= cur_code[7:0];
                                r_prev_code  <= cur_code;
                                r_prev_valid <= 1'b1;
                                r_status     <= ST_PIXEL;
                                r_pix        <= cur_code[7:0];
                                r_emitted    <= em_inc;
                                r_last       <= em_inc >= r_pixel_count;
                                if (em_inc >= r_pixel_count) r_finish <= ST_DONE;
                            end
                        end else if (13'(cur_code) > r_next_free) begin
                            r_finish <= ST_BAD_CODE;
                            r_status <= ST_BAD_CODE;
                            r_state  <= S_OUT;
                        end else begin
                            r_incoming <= cur_code;
                            if (13'(cur_code) == r_next_free) begin
                                r_code <= r_prev_code;
                                r_top  <= 13'd1;
                            end else begin
                                r_code <= cur_code;
                                r_top  <= 13'd0;
                            end
                            r_from_ram <= 1'b0;
                            r_state    <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    // RAM data for r_code is valid this cycle
                    if (13'(r_code) >= cc) begin
                        if (13'(r_code) == cc || 13'(r_code) == ec ||
                            r_top >= 13'(TableEntries)) begin
                            r_finish <= ST_BAD_CHAIN;
                            r_status <= ST_BAD_CHAIN;
                            r_state  <= S_OUT;
                        end else begin
                            r_top  <= r_top + 13'd1;
                            r_code <= pt_rdata;
                        end
                    end else if (r_top >= 13'(TableEntries)) begin
                        r_finish <= ST_BAD_CHAIN;
                        r_status <= ST_BAD_CHAIN;
                        r_state  <= S_OUT;
                    end else begin
                        r_first_sym <= r_code[7:0];
                        if (r_next_free < 13'(TableEntries)) begin
                            r_next_free <= nf_next;
                            if (nf_next == (13'd1 << r_width) && r_width < 4'(MaxWidth))
                                r_width <= r_width + 4'd1;
                        end
                        r_prev_code <= r_incoming;
                        r_depth     <= r_top + 13'd1;
                        r_state     <= S_POP;
                    end
                end
                S_POP: begin
                    // read of entry depth-1 issued; data arrives next cycle
                    r_depth <= r_depth - 13'd1;
                    r_state <= S_OUT;
                    r_from_ram <= 1'b1;
                end
                S_OUT: begin
                    if (r_from_ram) begin
                        r_from_ram <= 1'b0;
                        r_status   <= ST_PIXEL;
                        r_pix      <= sk_rdata;
                        r_emitted  <= em_inc;
                        r_last     <= em_inc >= r_pixel_count;
                        if (em_inc >= r_pixel_count) r_finish <= ST_DONE;
                    end else if (!r_valid) begin
                        r_valid <= 1'b1;
                    end else if (out_xfer) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_pixel_index = r_pix;
    assign o_last_pixel  = r_last;

    `ASSERT_IMPLIES(a_busy_no_take, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `ASSERT_IMPLIES(a_valid_in_out, i_clk, i_rst_n, r_valid, r_state == S_OUT)
    `ASSERT_IMPLIES(a_last_pixel, i_clk, i_rst_n, r_valid && r_last,
                    r_status == ST_PIXEL)
    `ASSERT_NEXT(a_done_sticky, i_clk, i_rst_n, r_finish != ST_PIXEL && !i_cfg_we,
                 r_finish == $past(r_finish))
endmodule

// ===== verif/gif_lzw_decoder_tb.sv =====
// Testbench for the GIF LZW decoder: directed table, then random LZW streams.
`timescale 1ns / 1ps
module gif_lzw_decoder_tb;
    import gld_pkg::*;

    typedef struct packed {
        t_status    status;
        logic [7:0] pix;
        logic       last;
    } t_lzw_result;

    typedef struct {
        bit          is_cfg;
        logic [0:0]  cfg_reg;
        logic [26:0] cfg_val;
        logic        op;
        logic [7:0]  data;
        logic        fin;
        bit          typed;
        t_status     want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_operation = OP_BYTE;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_final_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_status;
    logic [7:0]  o_pixel_index;
    logic        o_last_pixel;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = REG_MIN_SIZE;
    logic [26:0] i_cfg_data = 27'd0;

    gif_lzw_decoder dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [3:0]  cfg_size;
    logic [26:0] cfg_pixels;
    logic [7:0]  sfx_tbl [TableEntries];
    logic [11:0] pfx_tbl [TableEntries];
    logic [7:0]  str_stk [TableEntries];
    int          eff_bits, next_code, code_width, bitbuf, held, prev_code, first_sym, depth;
    bit          prev_ok, in_ended;
    logic [26:0] emitted;
    t_status     fstate;

    t_lzw_result pending_q[$];
    int          mismatches = 0;
    bit          quiet = 1'b0;
    int          items = 0;
    logic [7:0]  comp_bytes[$];
    int          str_len [TableEntries];

    function automatic void reset_dict();
        eff_bits   = (cfg_size < 2) ? 2 : (cfg_size > 8) ? 8 : int'(cfg_size);
        next_code  = (1 << eff_bits) + 2;
        code_width = eff_bits + 1;
        prev_ok    = 1'b0;
    endfunction

    function automatic void restart_decoder();
        reset_dict();
        bitbuf = 0; held = 0; prev_code = 0; first_sym = 0; depth = 0;
        emitted = '0; in_ended = 1'b0; fstate = ST_PIXEL;
    endfunction

    function automatic t_lzw_result halt(t_status st);
        t_lzw_result r;
        r = '0;
        fstate = st;
        r.status = st;
        return r;
    endfunction

    function automatic t_lzw_result give_pixel(logic [7:0] sym);
        t_lzw_result r;
        r = '0;
        emitted = emitted + 27'd1;
        r.status = ST_PIXEL;
        r.pix = sym;
        r.last = (emitted >= cfg_pixels);
        if (r.last) fstate = ST_DONE;
        return r;
    endfunction

    function automatic t_lzw_result decode_step(logic op, logic [7:0] b, logic fin);
        t_lzw_result r;
        int cc, ec, code, incoming, top;
        r = '0;
        if (fstate != ST_PIXEL) begin
            r.status = fstate;
            return r;
        end
        if (op == OP_BYTE) begin
            if (held > 16 || in_ended) begin
                r.status = ST_REFUSED;
            end else begin
                bitbuf = (bitbuf | (int'(b) << held)) & 24'hFFFFFF;
                held += 8;
                in_ended = fin;
                r.status = ST_TAKEN;
            end
            return r;
        end
        cc = 1 << eff_bits;
        ec = cc + 1;
        if (emitted >= cfg_pixels) return halt(ST_DONE);
        if (depth > 0) begin
            depth--;
            return give_pixel(str_stk[depth]);
        end
        forever begin
            if (held < code_width) begin
                if (in_ended) return halt(ST_TRUNC);
                r.status = ST_NEED;
                return r;
            end
            code = bitbuf & ((1 << code_width) - 1);
            bitbuf = bitbuf >> code_width;
            held -= code_width;
            if (code == cc) begin
                reset_dict();
                continue;
            end
            if (code == ec) return halt(ST_TRUNC);
            if (!prev_ok) begin
                if (code >= cc) return halt(ST_BAD_FIRST);
                first_sym = code;
                prev_code = code;
                prev_ok = 1'b1;
                return give_pixel(code[7:0]);
            end
            incoming = code;
            top = 0;
            if (code == next_code) begin
                str_stk[top] = first_sym[7:0];
                top++;
                code = prev_code;
            end else if (code > next_code) begin
                return halt(ST_BAD_CODE);
            end
            while (code >= cc) begin
                if (code == cc || code == ec || top >= TableEntries) return halt(ST_BAD_CHAIN);
                str_stk[top] = sfx_tbl[code];
                top++;
                code = pfx_tbl[code];
            end
            if (top >= TableEntries) return halt(ST_BAD_CHAIN);
            first_sym = code & 8'hFF;
            str_stk[top] = first_sym[7:0];
            top++;
            if (next_code < TableEntries) begin
                pfx_tbl[next_code] = prev_code[11:0];
                sfx_tbl[next_code] = first_sym[7:0];
                next_code++;
                if (next_code == (1 << code_width) && code_width < MaxWidth) code_width++;
            end
            prev_code = incoming & 12'hFFF;
            depth = top - 1;
            return give_pixel(str_stk[depth]);
        end
    endfunction

    // result side: random stall, compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_lzw_result e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d pix %0d", o_status, o_pixel_index);
                end else begin
                    e = pending_q.pop_front();
                    if (o_status !== e.status || o_pixel_index !== e.pix
                            || o_last_pixel !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp st %0d pix %0d last %0d,",
                                      " got st %0d pix %0d last %0d"},
                                     e.status, e.pix, e.last,
                                     o_status, o_pixel_index, o_last_pixel);
                    end
                end
            end
            i_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 24);
        end
    end

    task automatic send_item(input logic op, input logic [7:0] b, input logic fin,
                             input bit typed, input t_status want, output t_lzw_result r);
        while (!quiet && $urandom_range(0, 99) < 24) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_data_byte <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (o_stall);
        r = decode_step(op, b, fin);
        if (typed) begin
            r = '0;
            r.status = want;
        end
        pending_q.insert(pending_q.size(), r);
        items++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [26:0] val);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MIN_SIZE) cfg_size = val[3:0];
        else cfg_pixels = val;
        restart_decoder();
    endtask

    // Builds a well-formed code stream for the current size; returns its pixel total.
    task automatic build_stream(input int ncodes, output int npix);
        longint acc;
        int nacc, cc, w, nf, code, prv;
        bit fresh;
        acc = 0; nacc = 0; npix = 0; prv = 0;
        cc = 1 << eff_bits;
        w = eff_bits + 1;
        nf = cc + 2;
        fresh = 1'b1;
        comp_bytes.delete();
        for (int i = 0; i < ncodes + 1; i++) begin
            if (i == ncodes) begin
                code = ($urandom_range(0, 9) < 7) ? cc + 1 : -1;
            end else if ((i == 0 && $urandom_range(0, 1)) ||
                         (!fresh && $urandom_range(0, 15) == 0)) begin
                code = cc;
                nf = cc + 2;
                w = eff_bits + 1;
                fresh = 1'b1;
            end else if (fresh) begin
                code = $urandom_range(0, cc - 1);
                npix += 1;
                prv = code;
                fresh = 1'b0;
            end else begin
                code = $urandom_range(0, (nf > TableEntries - 1) ? TableEntries - 1 : nf);
                if (code == cc || code == cc + 1) code = $urandom_range(0, cc - 1);
                if (code == nf) npix += ((prv < cc) ? 1 : str_len[prv]) + 1;
                else npix += (code < cc) ? 1 : str_len[code];
                if (nf < TableEntries) begin
                    str_len[nf] = ((prv < cc) ? 1 : str_len[prv]) + 1;
                    nf++;
                end
                prv = code;
            end
            if (code >= 0) begin
                acc |= longint'(code) << nacc;
                nacc += w;
                // the width grows after the entry is added, like the decoder
                if (!fresh && code != cc && nf == (1 << w) && w < MaxWidth) w++;
                while (nacc >= 8) begin
                    comp_bytes.insert(comp_bytes.size(), acc[7:0]);
                    acc >>= 8;
                    nacc -= 8;
                end
            end
        end
        if (nacc > 0) comp_bytes.insert(comp_bytes.size(), acc[7:0]);
    endtask

    t_stim_row dir_rows[$];

    function automatic void add_row(bit c, logic [0:0] rg, logic [26:0] v, logic op,
                                    logic [7:0] d, logic f, bit t, t_status w);
        t_stim_row s;
        s.is_cfg = c; s.cfg_reg = rg; s.cfg_val = v; s.op = op; s.data = d; s.fin = f;
        s.typed = t; s.want = w;
        dir_rows.insert(dir_rows.size(), s);
    endfunction

    initial begin
        t_lzw_result r;
        int npix, bi, guard, frame, nsz;
        logic [7:0] bval;
        bit corrupt;

        cfg_size = 4'd8;
        cfg_pixels = 27'd1;
        restart_decoder();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: size 8, one pixel
        add_row(0, REG_MIN_SIZE, 0, OP_PIXEL, 8'h00, 0, 1, ST_NEED);
        add_row(0, REG_MIN_SIZE, 0, OP_BYTE,  8'hFF, 0, 1, ST_TAKEN);
        add_row(0, REG_MIN_SIZE, 0, OP_BYTE,  8'hFF, 0, 1, ST_TAKEN);
        add_row(0, REG_MIN_SIZE, 0, OP_BYTE,  8'h00, 0, 1, ST_TAKEN);
        add_row(0, REG_MIN_SIZE, 0, OP_BYTE,  8'h00, 0, 1, ST_REFUSED);   // buffer full
        add_row(0, REG_MIN_SIZE, 0, OP_PIXEL, 8'h00, 0, 1, ST_BAD_FIRST); // code 511
        add_row(0, REG_MIN_SIZE, 0, OP_PIXEL, 8'h00, 0, 1, ST_BAD_FIRST); // sticky
        // size 2: clear, literal 1, then truncated
        add_row(1, REG_MIN_SIZE, 27'd2, 0, 0, 0, 0, ST_PIXEL);
        add_row(1, REG_PIXELS, 27'd2, 0, 0, 0, 0, ST_PIXEL);
        add_row(0, REG_MIN_SIZE, 0, OP_BYTE,  8'h0C, 1, 1, ST_TAKEN);
        add_row(0, REG_MIN_SIZE, 0, OP_PIXEL, 8'h00, 0, 0, ST_PIXEL);
        add_row(0, REG_MIN_SIZE, 0, OP_PIXEL, 8'h00, 0, 1, ST_TRUNC);
        // size above range, pixel count 100000000, bytes after the final one
        add_row(1, REG_MIN_SIZE, 27'd15, 0, 0, 0, 0, ST_PIXEL);
        add_row(1, REG_PIXELS, 27'd100000000, 0, 0, 0, 0, ST_PIXEL);
        add_row(0, REG_MIN_SIZE, 0, OP_BYTE,  8'h01, 1, 1, ST_TAKEN);
        add_row(0, REG_MIN_SIZE, 0, OP_BYTE,  8'h55, 0, 1, ST_REFUSED);
        add_row(0, REG_MIN_SIZE, 0, OP_PIXEL, 8'h00, 0, 1, ST_TRUNC);
        // size below range: end code, then code past the next free one, then count reached
        add_row(1, REG_MIN_SIZE, 27'd0, 0, 0, 0, 0, ST_PIXEL);
        add_row(1, REG_PIXELS, 27'd1, 0, 0, 0, 0, ST_PIXEL);
        add_row(0, REG_MIN_SIZE, 0, OP_BYTE,  8'h05, 0, 1, ST_TAKEN);
        add_row(0, REG_MIN_SIZE, 0, OP_PIXEL, 8'h00, 0, 1, ST_TRUNC);
        add_row(1, REG_PIXELS, 27'd5, 0, 0, 0, 0, ST_PIXEL);
        add_row(0, REG_MIN_SIZE, 0, OP_BYTE,  8'h39, 0, 1, ST_TAKEN);
        add_row(0, REG_MIN_SIZE, 0, OP_PIXEL, 8'h00, 0, 0, ST_PIXEL);
        add_row(0, REG_MIN_SIZE, 0, OP_PIXEL, 8'h00, 0, 1, ST_BAD_CODE);
        add_row(1, REG_PIXELS, 27'd1, 0, 0, 0, 0, ST_PIXEL);
        add_row(0, REG_MIN_SIZE, 0, OP_BYTE,  8'h01, 0, 1, ST_TAKEN);
        add_row(0, REG_MIN_SIZE, 0, OP_PIXEL, 8'h00, 0, 0, ST_PIXEL);
        add_row(0, REG_MIN_SIZE, 0, OP_PIXEL, 8'h00, 0, 1, ST_DONE);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) write_reg(dir_rows[k].cfg_reg, dir_rows[k].cfg_val);
            else send_item(dir_rows[k].op, dir_rows[k].data, dir_rows[k].fin,
                           dir_rows[k].typed, dir_rows[k].want, r);
        end

        frame = 0;
        while (items < 850) begin
            nsz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 8);
            write_reg(REG_MIN_SIZE, 27'(nsz));
            build_stream($urandom_range(2, 30), npix);
            corrupt = ($urandom_range(0, 4) == 0);
            if (corrupt && comp_bytes.size() > 0) begin
                bi = $urandom_range(0, comp_bytes.size() - 1);
                comp_bytes[bi] = ($urandom_range(0, 1))
                                 ? comp_bytes[bi] ^ (8'h1 << $urandom_range(0, 7))
                                 : 8'($urandom_range(0, 255));
            end
            case ($urandom_range(0, 7))
                0:       write_reg(REG_PIXELS,
                                   27'((npix > 1) ? npix - $urandom_range(1, npix - 1) : 1));
                1:       write_reg(REG_PIXELS, 27'(npix + $urandom_range(1, 3)));
                default: write_reg(REG_PIXELS, 27'(npix));
            endcase
            quiet = (frame >= 6 && frame < 10);
            bi = 0;
            guard = 0;
            r = '0;
            while (fstate == ST_PIXEL && guard < 400) begin
                // hold the input until all results are out
                if (frame == 4 && guard == 6) wait_drained();
                if (bi < comp_bytes.size() && (r.status == ST_NEED || $urandom_range(0, 2) == 0)) begin
                    bval = comp_bytes[bi];
                    send_item(OP_BYTE, bval, bi == comp_bytes.size() - 1, 0, ST_PIXEL, r);
                    if (r.status == ST_TAKEN) bi++;
                end else begin
                    send_item(OP_PIXEL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0,
                              ST_PIXEL, r);
                end
                guard++;
            end
            repeat ($urandom_range(0, 2))
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 0, ST_PIXEL, r);
            frame++;
        end
        quiet = 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gld_pkg.sv
rtl/gld_ram.sv
rtl/gif_lzw_decoder.sv
verif/gif_lzw_decoder_tb.sv
